// ===== sv/kvlp_pkg.sv =====
// ----------------------------------------------------------------------------
// kvlp_pkg
// Types, codes and sizes shared by the key/value line parser modules.
// ----------------------------------------------------------------------------
package kvlp_pkg;

  // store sizes
  localparam int KEY_MAX   = 127;
  localparam int VALUE_MAX = 255;
  localparam int KEY_AW    = $clog2(KEY_MAX);
  localparam int VAL_AW    = $clog2(VALUE_MAX);
  localparam int KEY_CW    = $clog2(KEY_MAX + 1);
  localparam int VAL_CW    = $clog2(VALUE_MAX + 1);
  localparam int CMP_W     = 16;

  // item field widths
  localparam int LINE_W = 16;
  localparam int KLEN_W = 7;
  localparam int VLEN_W = 8;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 8;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  // character codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  typedef enum logic [1:0] {
    CMD_FEED   = 2'd0,
    CMD_END    = 2'd1,
    CMD_RD_KEY = 2'd2,
    CMD_RD_VAL = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    KIND_ENTRY     = 2'd0,
    KIND_NOEQ      = 2'd1,
    KIND_EMPTY_KEY = 2'd2,
    KIND_READ      = 2'd3
  } kind_e_t;

  typedef enum logic [5:0] {
    MODE_START = 6'b000001,
    MODE_SKIP  = 6'b000010,
    MODE_KEY   = 6'b000100,
    MODE_VLEAD = 6'b001000,
    MODE_VBODY = 6'b010000,
    MODE_VDROP = 6'b100000
  } mode_e_t;

  typedef struct packed {
    cmd_e_t            cmd;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  read_index;
  } item_t;

  typedef struct packed {
    logic              valid;
    kind_e_t           kind;
    logic [LINE_W-1:0] line_number;
    logic [KLEN_W-1:0] key_length;
    logic [VLEN_W-1:0] value_length;
    logic [BYTE_W-1:0] read_byte;
  } rslt_t;

  typedef struct packed {
    logic              we;
    logic [KEY_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } kwr_t;

  typedef struct packed {
    logic              we;
    logic [VAL_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } vwr_t;

endpackage

// ===== sv/kvlp_ram.sv =====
// ----------------------------------------------------------------------------
// kvlp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kvlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/kvlp_parser.sv =====
// ----------------------------------------------------------------------------
// kvlp_parser
// Line parse state, counters and trimmed lengths; store writes and results.
// ----------------------------------------------------------------------------
module kvlp_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  kvlp_pkg::item_t item,
  output kvlp_pkg::rslt_t rslt,
  output kvlp_pkg::kwr_t  kwr,
  output kvlp_pkg::vwr_t  vwr
);

  kvlp_pkg::mode_e_t                 mode_r, mode_nxt;
  logic [kvlp_pkg::LINE_W-1:0]       line_r, line_nxt;
  logic [kvlp_pkg::KEY_CW-1:0]       kc_r, kc_nxt, ktl_r, ktl_nxt;
  logic [kvlp_pkg::VAL_CW-1:0]       vc_r, vc_nxt, vtl_r, vtl_nxt;

  logic [7:0]                  c;
  logic                        is_blank;
  logic                        is_cmt;
  logic                        do_end;
  logic                        key_put;
  logic                        val_put;
  logic [kvlp_pkg::KEY_CW-1:0] kbase, knew;
  logic [kvlp_pkg::VAL_CW-1:0] vbase, vnew;

  assign c        = item.data_byte;
  assign is_blank = (c == kvlp_pkg::CH_SPACE) || (c == kvlp_pkg::CH_TAB);
  assign is_cmt   = (c == kvlp_pkg::CH_HASH) || (c == kvlp_pkg::CH_SEMI);

  // next state and results for the item in the input register
  always_comb begin
    mode_nxt = mode_r;
    line_nxt = line_r;
    kc_nxt   = kc_r;
    ktl_nxt  = ktl_r;
    vc_nxt   = vc_r;
    vtl_nxt  = vtl_r;
    rslt     = '0;
    kwr      = '0;
    vwr      = '0;
    do_end   = 1'b0;
    key_put  = 1'b0;
    val_put  = 1'b0;
    kbase    = kc_r;
    vbase    = vc_r;
    knew     = kc_r;
    vnew     = vc_r;

    unique case (item.cmd)
      kvlp_pkg::CMD_FEED: begin
        if (c == kvlp_pkg::CH_LF) begin
          do_end = 1'b1;
        end else begin
          unique case (mode_r)
            kvlp_pkg::MODE_START: begin
              if (is_blank || c == kvlp_pkg::CH_CR) begin
                mode_nxt = mode_r;
              end else if (is_cmt) begin
                mode_nxt = kvlp_pkg::MODE_SKIP;
              end else begin
                kc_nxt  = '0;
                ktl_nxt = '0;
                vc_nxt  = '0;
                vtl_nxt = '0;
                if (c == kvlp_pkg::CH_EQ) begin
                  mode_nxt = kvlp_pkg::MODE_VLEAD;
                end else begin
                  key_put  = 1'b1;
                  kbase    = '0;
                  mode_nxt = kvlp_pkg::MODE_KEY;
                end
              end
            end
            kvlp_pkg::MODE_KEY: begin
              if (c == kvlp_pkg::CH_EQ) begin
                mode_nxt = kvlp_pkg::MODE_VLEAD;
              end else begin
                key_put = 1'b1;
              end
            end
            kvlp_pkg::MODE_VLEAD: begin
              if (is_blank) begin
                mode_nxt = mode_r;
              end else if (is_cmt) begin
                mode_nxt = kvlp_pkg::MODE_VDROP;
              end else begin
                val_put  = 1'b1;
                mode_nxt = kvlp_pkg::MODE_VBODY;
              end
            end
            kvlp_pkg::MODE_VBODY: begin
              if (is_cmt) begin
                mode_nxt = kvlp_pkg::MODE_VDROP;
              end else begin
                val_put = 1'b1;
              end
            end
            kvlp_pkg::MODE_SKIP, kvlp_pkg::MODE_VDROP: begin
              mode_nxt = mode_r;
            end
            default: begin
              mode_nxt = kvlp_pkg::MODE_START;
            end
          endcase
        end
      end
      kvlp_pkg::CMD_END: begin
        do_end = (mode_r != kvlp_pkg::MODE_START) && (mode_r != kvlp_pkg::MODE_SKIP);
      end
      kvlp_pkg::CMD_RD_KEY, kvlp_pkg::CMD_RD_VAL: begin
        rslt.valid        = 1'b1;
        rslt.kind         = kvlp_pkg::KIND_READ;
        rslt.key_length   = kvlp_pkg::KLEN_W'(ktl_r);
        rslt.value_length = kvlp_pkg::VLEN_W'(vtl_r);
      end
      default: begin
        rslt = '0;
      end
    endcase

    // append a key byte, truncating at the store size
    if (key_put) begin
      if (kbase < kvlp_pkg::KEY_CW'(kvlp_pkg::KEY_MAX)) begin
        kwr.we   = go;
        kwr.addr = kvlp_pkg::KEY_AW'(kbase);
        kwr.data = c;
        knew     = kbase + kvlp_pkg::KEY_CW'(1);
      end else begin
        knew = kbase;
      end
      kc_nxt = knew;
      if (!is_blank) begin
        ktl_nxt = knew;
      end
    end

    // append a value byte, truncating at the store size
    if (val_put) begin
      if (vbase < kvlp_pkg::VAL_CW'(kvlp_pkg::VALUE_MAX)) begin
        vwr.we   = go;
        vwr.addr = kvlp_pkg::VAL_AW'(vbase);
        vwr.data = c;
        vnew     = vbase + kvlp_pkg::VAL_CW'(1);
      end else begin
        vnew = vbase;
      end
      vc_nxt = vnew;
      if (!is_blank) begin
        vtl_nxt = vnew;
      end
    end

    // line end: report, count the line, restart
    if (do_end) begin
      if (mode_r == kvlp_pkg::MODE_KEY) begin
        rslt.valid       = 1'b1;
        rslt.kind        = kvlp_pkg::KIND_NOEQ;
        rslt.line_number = line_r;
      end else if (mode_r == kvlp_pkg::MODE_VLEAD || mode_r == kvlp_pkg::MODE_VBODY ||
                   mode_r == kvlp_pkg::MODE_VDROP) begin
        rslt.valid       = 1'b1;
        rslt.line_number = line_r;
        if (ktl_r == '0) begin
          rslt.kind = kvlp_pkg::KIND_EMPTY_KEY;
        end else begin
          rslt.kind         = kvlp_pkg::KIND_ENTRY;
          rslt.key_length   = kvlp_pkg::KLEN_W'(ktl_r);
          rslt.value_length = kvlp_pkg::VLEN_W'(vtl_r);
        end
      end
      if (line_r != kvlp_pkg::LINE_MAX) begin
        line_nxt = line_r + kvlp_pkg::LINE_W'(1);
      end
      mode_nxt = kvlp_pkg::MODE_START;
    end

    // end of data starts a fresh file
    if (item.cmd == kvlp_pkg::CMD_END) begin
      mode_nxt = kvlp_pkg::MODE_START;
      line_nxt = kvlp_pkg::LINE_W'(1);
    end
  end

  // state registers, advanced once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= kvlp_pkg::MODE_START;
      line_r <= kvlp_pkg::LINE_W'(1);
      kc_r   <= '0;
      ktl_r  <= '0;
      vc_r   <= '0;
      vtl_r  <= '0;
    end else if (go) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      kc_r   <= kc_nxt;
      ktl_r  <= ktl_nxt;
      vc_r   <= vc_nxt;
      vtl_r  <= vtl_nxt;
    end
  end

  // line counter starts at one and saturates, so never wraps to zero
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line counter reached zero");

  // trimmed key length never runs ahead of stored key bytes
  a_key_trim: assert property (@(posedge clk) disable iff (!rst_n)
    ktl_r <= kc_r)
    else $error("trimmed key length beyond key count");

  // trimmed value length never runs ahead of stored value bytes
  a_val_trim: assert property (@(posedge clk) disable iff (!rst_n)
    vtl_r <= vc_r)
    else $error("trimmed value length beyond value count");

endmodule

// ===== sv/key_value_line_parser.sv =====
// ----------------------------------------------------------------------------
// key_value_line_parser
// Byte-serial key=value line parser with key and value byte stores.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one command per item: feed a text byte, end of data, or read
//   a stored key or value byte. in_tuser holds the command, in_tdata the byte
//   and the read index. out_* carries at most one result per item: an entry
//   at the end of a key=value line, a missing '=' or empty key error, or the
//   byte asked for by a read command, with stored lengths (not on errors) and
//   line number (not on reads). Commented and blank lines give no result.
//   An item is registered on acceptance, together with the store read at its
//   index; its result is registered in the result register once that is free
//   and offered on out_*. Throughput is one item per cycle while the receiver
//   takes results, set by the single parse step between the input register
//   and the result register.
//   When the receiver stalls, the result register holds; one further item is
//   taken into the input register and then in_tready drops until the result
//   is taken. Reset sets line start, line number one and empty lengths; the
//   stores are not cleared, since only bytes written on the current line are
//   ever returned.
// ----------------------------------------------------------------------------
module key_value_line_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // data_byte [7:0], read_index [15:8]
  input  logic [1:0]  in_tuser,  // command [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // line_number [15:0], key_length [22:16],
                                 // value_length [30:23], read_byte [38:31]
  output logic [1:0]  out_tuser  // result_kind [1:0]
);

  logic                              in_acc;
  logic                              s1_go;
  logic                              s1_v_r;
  kvlp_pkg::item_t                   s1_item_r;
  kvlp_pkg::item_t                   in_item;
  kvlp_pkg::rslt_t                   rslt;
  kvlp_pkg::rslt_t                   rslt_fin;
  kvlp_pkg::rslt_t                   out_r;
  logic                              out_v_r;
  kvlp_pkg::kwr_t                    kwr;
  kvlp_pkg::vwr_t                    vwr;
  logic [kvlp_pkg::KEY_AW-1:0]       k_raddr;
  logic [kvlp_pkg::VAL_AW-1:0]       v_raddr;
  logic [kvlp_pkg::BYTE_W-1:0]       k_rdata;
  logic [kvlp_pkg::BYTE_W-1:0]       v_rdata;
  logic                              kbyp_hit_r;
  logic                              vbyp_hit_r;
  logic [kvlp_pkg::BYTE_W-1:0]       kbyp_r;
  logic [kvlp_pkg::BYTE_W-1:0]       vbyp_r;
  logic [kvlp_pkg::BYTE_W-1:0]       kbyte;
  logic [kvlp_pkg::BYTE_W-1:0]       vbyte;

  // handshake: input register advances when the result register is free
  assign s1_go     = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;

  assign in_item.cmd        = kvlp_pkg::cmd_e_t'(in_tuser);
  assign in_item.data_byte  = in_tdata[7:0];
  assign in_item.read_index = in_tdata[15:8];

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
  end

  // parse step
  kvlp_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (s1_go),
    .item  (s1_item_r),
    .rslt  (rslt),
    .kwr   (kwr),
    .vwr   (vwr)
  );

  // stores, read at acceptance of an item
  assign k_raddr = kvlp_pkg::KEY_AW'(in_item.read_index);
  assign v_raddr = kvlp_pkg::VAL_AW'(in_item.read_index);

  kvlp_ram #(
    .WIDTH (kvlp_pkg::BYTE_W),
    .DEPTH (kvlp_pkg::KEY_MAX)
  ) u_key_ram (
    .clk   (clk),
    .we    (kwr.we),
    .waddr (kwr.addr),
    .wdata (kwr.data),
    .re    (in_acc),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  kvlp_ram #(
    .WIDTH (kvlp_pkg::BYTE_W),
    .DEPTH (kvlp_pkg::VALUE_MAX)
  ) u_val_ram (
    .clk   (clk),
    .we    (vwr.we),
    .waddr (vwr.addr),
    .wdata (vwr.data),
    .re    (in_acc),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  // forward a byte written in the same cycle as the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kbyp_hit_r <= 1'b0;
      vbyp_hit_r <= 1'b0;
    end else if (in_acc) begin
      kbyp_hit_r <= kwr.we && (kwr.addr == k_raddr);
      vbyp_hit_r <= vwr.we && (vwr.addr == v_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kbyp_r <= kwr.data;
      vbyp_r <= vwr.data;
    end
  end

  assign kbyte = kbyp_hit_r ? kbyp_r : k_rdata;
  assign vbyte = vbyp_hit_r ? vbyp_r : v_rdata;

  // fill in the read byte, zero beyond the trimmed length
  always_comb begin
    rslt_fin = rslt;
    if (s1_item_r.cmd == kvlp_pkg::CMD_RD_KEY) begin
      if (kvlp_pkg::CMP_W'(s1_item_r.read_index) < kvlp_pkg::CMP_W'(rslt.key_length)) begin
        rslt_fin.read_byte = kbyte;
      end
    end else if (s1_item_r.cmd == kvlp_pkg::CMD_RD_VAL) begin
      if (kvlp_pkg::CMP_W'(s1_item_r.read_index) < kvlp_pkg::CMP_W'(rslt.value_length)) begin
        rslt_fin.read_byte = vbyte;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go) begin
      out_v_r <= rslt_fin.valid;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_r <= rslt_fin;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {1'b0, out_r.read_byte, out_r.value_length, out_r.key_length,
                       out_r.line_number};

  // forwarding flags only change when an item is accepted
  a_byp_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable({kbyp_hit_r, vbyp_hit_r}) |-> $past(in_acc))
    else $error("store forwarding without an accepted item");

  // an entry always carries a non-empty key
  a_entry_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.kind == kvlp_pkg::KIND_ENTRY) |-> (out_r.key_length != '0))
    else $error("entry reported with empty key");

  // a stalled item in the input register is kept
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_go) |=> (s1_v_r && $stable(s1_item_r)))
    else $error("stalled item lost from input register");

endmodule

// ===== tb/key_value_line_parser_tb.sv =====
// ----------------------------------------------------------------------------
// key_value_line_parser_tb
// Drives text bytes, end-of-data marks and store reads into the parser and
// checks every result against a behavioural copy of the line parser kept in a
// small scoreboard. Both sides idle at random, the receiver holds off once
// for a long stretch, and the sender pauses once until every result is in.
// ----------------------------------------------------------------------------
module key_value_line_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kvlp_pkg::*;

  localparam int IDLE_PCT     = 30;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_PRINTED  = 40;

  typedef struct packed {
    kind_e_t           kind;
    logic [LINE_W-1:0] line_number;
    logic [KLEN_W-1:0] key_length;
    logic [VLEN_W-1:0] value_length;
    logic [BYTE_W-1:0] read_byte;
  } parse_result_t;

  // line parser copy and result queue
  class kv_parse_scoreboard;
    mode_e_t           mode;
    logic [LINE_W-1:0] line_no;
    int unsigned       key_cnt;
    int unsigned       key_len;
    int unsigned       val_cnt;
    int unsigned       val_len;
    logic [7:0]        key_mem [KEY_MAX];
    logic [7:0]        val_mem [VALUE_MAX];
    parse_result_t     parsed_results [$];
    int unsigned       mismatches;

    function new();
      mode       = MODE_START;
      line_no    = 1;
      key_cnt    = 0;
      key_len    = 0;
      val_cnt    = 0;
      val_len    = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return parsed_results.size();
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
    endfunction

    function bit is_comment(logic [7:0] c);
      return c == CH_HASH || c == CH_SEMI;
    endfunction

    function void push(kind_e_t kind, logic [LINE_W-1:0] ln, int unsigned klen,
                       int unsigned vlen, logic [7:0] rb);
      parse_result_t r;
      r.kind         = kind;
      r.line_number  = ln;
      r.key_length   = KLEN_W'(klen);
      r.value_length = VLEN_W'(vlen);
      r.read_byte    = rb;
      parsed_results.push_back(r);
    endfunction

    function void store_key(logic [7:0] c);
      if (key_cnt < KEY_MAX) begin
        key_mem[key_cnt] = c;
        key_cnt++;
      end
      if (!is_blank(c)) key_len = key_cnt;
    endfunction

    function void store_value(logic [7:0] c);
      if (val_cnt < VALUE_MAX) begin
        val_mem[val_cnt] = c;
        val_cnt++;
      end
      if (!is_blank(c)) val_len = val_cnt;
    endfunction

    // line end: entry or error for any line that began a key or value
    function void close_line();
      if (mode == MODE_KEY) begin
        push(KIND_NOEQ, line_no, 0, 0, 8'h00);
      end else if (mode inside {MODE_VLEAD, MODE_VBODY, MODE_VDROP}) begin
        if (key_len == 0) push(KIND_EMPTY_KEY, line_no, 0, 0, 8'h00);
        else push(KIND_ENTRY, line_no, key_len, val_len, 8'h00);
      end
      if (line_no != LINE_MAX) line_no++;
      mode = MODE_START;
    endfunction

    function void take_byte(logic [7:0] c);
      if (c == CH_LF) begin
        close_line();
        return;
      end
      case (mode)
        MODE_START: begin
          if (is_comment(c)) begin
            mode = MODE_SKIP;
          end else if (!is_blank(c) && c != CH_CR) begin
            key_cnt = 0;
            key_len = 0;
            val_cnt = 0;
            val_len = 0;
            if (c == CH_EQ) begin
              mode = MODE_VLEAD;
            end else begin
              store_key(c);
              mode = MODE_KEY;
            end
          end
        end
        MODE_KEY: begin
          if (c == CH_EQ) mode = MODE_VLEAD;
          else store_key(c);
        end
        MODE_VLEAD: begin
          if (is_comment(c)) begin
            mode = MODE_VDROP;
          end else if (!is_blank(c)) begin
            store_value(c);
            mode = MODE_VBODY;
          end
        end
        MODE_VBODY: begin
          if (is_comment(c)) mode = MODE_VDROP;
          else store_value(c);
        end
        default: ;
      endcase
    endfunction

    function void note_item(cmd_e_t cmd, logic [7:0] ch, logic [7:0] idx);
      case (cmd)
        CMD_FEED: take_byte(ch);
        CMD_END: begin
          if (mode != MODE_START && mode != MODE_SKIP) close_line();
          mode    = MODE_START;
          line_no = 1;
        end
        CMD_RD_KEY: push(KIND_READ, 0, key_len, val_len,
                         (idx < key_len) ? key_mem[idx] : 8'h00);
        default: push(KIND_READ, 0, key_len, val_len,
                      (idx < val_len) ? val_mem[idx] : 8'h00);
      endcase
    endfunction

    // only the first few mismatches are printed, all are counted
    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task check_result(logic [1:0] kind, logic [39:0] d);
      parse_result_t e;
      if (parsed_results.size() == 0) begin
        report($sformatf("result of kind %0d with nothing awaited", kind));
        return;
      end
      e = parsed_results.pop_front();
      if (kind !== e.kind)
        report($sformatf("result_kind %0d, expected %0d", kind, e.kind));
      if (d[15:0] !== e.line_number)
        report($sformatf("line_number %0d, expected %0d", d[15:0], e.line_number));
      if (d[22:16] !== e.key_length)
        report($sformatf("key_length %0d, expected %0d", d[22:16], e.key_length));
      if (d[30:23] !== e.value_length)
        report($sformatf("value_length %0d, expected %0d", d[30:23], e.value_length));
      if (d[38:31] !== e.read_byte)
        report($sformatf("read_byte %0h, expected %0h", d[38:31], e.read_byte));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;  // data_byte [7:0], read_index [15:8]
  logic [1:0]  in_tuser;  // command [1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata; // line_number, key_length, value_length, read_byte
  logic [1:0]  out_tuser; // result_kind [1:0]

  kv_parse_scoreboard parse_check;
  bit                 steady;
  bit                 hold_req;
  int unsigned        items_sent;

  key_value_line_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one item per call, with random idle cycles ahead of it outside steady phases
  task automatic send_item(cmd_e_t cmd, logic [7:0] ch, logic [7:0] idx);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {idx, ch};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    parse_check.note_item(cmd, ch, idx);
    items_sent++;
  endtask

  task automatic feed_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(CMD_FEED, s[i], 8'h00);
  endtask

  function automatic logic [7:0] blank_char(bit with_cr);
    case ($urandom_range(0, with_cr ? 2 : 1))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] key_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return CH_SPACE;
    if (r < 14) return CH_TAB;
    if (r < 17) return 8'($urandom_range(0, 255));
    if (r < 27) return 8'($urandom_range(48, 57));
    return 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] value_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return CH_SPACE;
    if (r < 14) return CH_TAB;
    if (r < 17) return CH_CR;
    if (r < 19) return CH_EQ;
    if (r < 23) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(33, 126));
  endfunction

  // mostly well-formed key=value line with random content
  task automatic send_line();
    int nkey;
    repeat ($urandom_range(0, 2)) send_item(CMD_FEED, blank_char(1), 8'h00);
    nkey = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
    repeat (nkey) send_item(CMD_FEED, key_char(), 8'h00);
    repeat ($urandom_range(0, 2)) send_item(CMD_FEED, blank_char(0), 8'h00);
    if ($urandom_range(0, 19) != 0) send_item(CMD_FEED, CH_EQ, 8'h00);
    repeat ($urandom_range(0, 2)) send_item(CMD_FEED, blank_char(0), 8'h00);
    repeat ($urandom_range(0, 10)) send_item(CMD_FEED, value_char(), 8'h00);
    if ($urandom_range(0, 4) == 0) begin
      send_item(CMD_FEED, $urandom_range(0, 1) ? CH_HASH : CH_SEMI, 8'h00);
      repeat ($urandom_range(0, 3)) send_item(CMD_FEED, value_char(), 8'h00);
    end
    if ($urandom_range(0, 9) == 0) send_item(CMD_FEED, CH_CR, 8'h00);
    send_item(CMD_FEED, CH_LF, 8'h00);
  endtask

  // reads mostly near the stored lengths, sometimes anywhere
  task automatic send_reads(int n);
    logic [7:0] idx;
    repeat (n) begin
      idx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 12));
      send_item($urandom_range(0, 1) ? CMD_RD_KEY : CMD_RD_VAL,
                8'($urandom_range(0, 255)), idx);
    end
  endtask

  // key and value longer than the stores, then reads around the limits
  task automatic send_long_line();
    repeat (130) send_item(CMD_FEED, 8'($urandom_range(97, 122)), 8'h00);
    send_item(CMD_FEED, CH_EQ, 8'h00);
    repeat (260) send_item(CMD_FEED, 8'($urandom_range(65, 90)), 8'h00);
    send_item(CMD_FEED, CH_LF, 8'h00);
    send_item(CMD_RD_KEY, 8'h00, 8'd0);
    send_item(CMD_RD_KEY, 8'h00, 8'd126);
    send_item(CMD_RD_KEY, 8'h00, 8'd127);
    send_item(CMD_RD_VAL, 8'h00, 8'd254);
    send_item(CMD_RD_VAL, 8'h00, 8'd255);
  endtask

  // receiver: random stalls, one long hold on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      parse_check.check_result(out_tuser, out_tdata);
  end

  // watchdog on cycles with no item moving on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("key_value_line_parser verification failed");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned start;
    bit          held;
    bit          paused;
    int          pick;
    parse_check = new();
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= CMD_FEED;
    rst_n      <= 1'b0;
    steady     = 1'b0;
    hold_req   = 1'b0;
    items_sent = 0;
    held       = 1'b0;
    paused     = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty read, entry, comment, blank, both errors, trimming
    send_item(CMD_RD_VAL, 8'hFF, 8'hFF);
    feed_text("a=b\n");
    send_item(CMD_RD_KEY, 8'h00, 8'd0);
    send_item(CMD_RD_VAL, 8'h00, 8'd1);
    feed_text(";\n");
    feed_text("\t\015\n");
    feed_text("=v\n");
    feed_text("k\n");
    feed_text("k =v #\n");
    // extreme byte values as key and value
    send_item(CMD_FEED, 8'hFF, 8'h00);
    send_item(CMD_FEED, CH_EQ, 8'h00);
    send_item(CMD_FEED, 8'h00, 8'h00);
    send_item(CMD_FEED, CH_LF, 8'h00);
    send_item(CMD_RD_KEY, 8'h00, 8'd0);
    send_item(CMD_RD_VAL, 8'hFF, 8'd0);
    // end of data with a pending line, then with nothing pending
    feed_text("z");
    send_item(CMD_END, 8'h00, 8'h00);
    send_item(CMD_END, 8'hFF, 8'h00);

    // random part
    start = items_sent;
    send_long_line();
    while (items_sent - start < RANDOM_ITEMS) begin
      steady = (items_sent - start >= 800) && (items_sent - start < 1000);
      if (!held && items_sent - start > 600) begin
        held     = 1'b1;
        hold_req = 1'b1;
        send_reads(24);
      end
      if (!paused && items_sent - start > 1200) begin
        paused = 1'b1;
        in_tvalid <= 1'b0;
        do @(posedge clk); while (parse_check.pending() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        send_line();
      end else if (pick < 66) begin
        repeat ($urandom_range(0, 2)) send_item(CMD_FEED, blank_char(1), 8'h00);
        if ($urandom_range(0, 1)) begin
          send_item(CMD_FEED, $urandom_range(0, 1) ? CH_HASH : CH_SEMI, 8'h00);
          repeat ($urandom_range(0, 5)) send_item(CMD_FEED, value_char(), 8'h00);
        end
        send_item(CMD_FEED, CH_LF, 8'h00);
      end else if (pick < 74) begin
        repeat ($urandom_range(1, 6))
          send_item(CMD_FEED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) send_item(CMD_FEED, CH_LF, 8'h00);
      end else if (pick < 90) begin
        send_reads($urandom_range(1, 4));
      end else if (pick < 95) begin
        send_item(CMD_END, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (pick < 97) begin
        send_long_line();
      end else begin
        // line cut short by end of data
        repeat ($urandom_range(1, 4)) send_item(CMD_FEED, key_char(), 8'h00);
        if ($urandom_range(0, 1)) send_item(CMD_FEED, CH_EQ, 8'h00);
        send_item(CMD_END, 8'h00, 8'h00);
      end
    end

    // end of data starts over at line one
    steady = 1'b1;
    send_item(CMD_END, 8'h00, 8'h00);
    feed_text("a=1\n");
    feed_text("b\n");
    send_item(CMD_END, 8'h00, 8'h00);
    feed_text("c=2\n");
    steady = 1'b0;

    // drain
    in_tvalid <= 1'b0;
    while (parse_check.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (parse_check.mismatches == 0)
      $display("key_value_line_parser verification clean");
    else
      $display("key_value_line_parser verification failed");
    $finish;
  end

endmodule
